// ----- sv/wse_pkg.sv -----
// Shared types and constants of the wheel speed estimator.
package wse_pkg;

  // Ring depth default
  localparam int WINDOW_DEPTH_DEF = 10;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int SPEED_W  = 16;
  localparam int DIST_W   = 16;
  localparam int TMO_W    = 24;
  localparam int MARGIN_W = 16;

  // Divider: dividend is distance * 1000, at most 65535000 (26 bits)
  localparam int PROD_W = 26;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam logic [PROD_W-1:0] UM_PER_MM = PROD_W'(1000);

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_DIST    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MARGIN  = 2'd2;

  // Register reset values
  localparam logic [DIST_W-1:0]   DIST_RST    = DIST_W'(24300);
  localparam logic [TMO_W-1:0]    TIMEOUT_RST = TMO_W'(50000);
  localparam logic [MARGIN_W-1:0] MARGIN_RST  = MARGIN_W'(1000);

  // Item opcodes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PERIOD,
    S_SUM,
    S_MEAN,
    S_TEST,
    S_DONE
  } state_t;

endpackage

// ----- sv/wse_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface wse_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [wse_pkg::TIME_W-1:0]   time_us;

  modport source (output valid, output opcode, output time_us, input ready);
  modport sink   (input valid, input opcode, input time_us, output ready);
endinterface

interface wse_result_if;
  logic                         valid;
  logic                         ready;
  logic [wse_pkg::SPEED_W-1:0]  speed_mm_s;
  logic                         sample_taken;
  logic                         rejected;

  modport source (output valid, output speed_mm_s, output sample_taken, output rejected,
                  input ready);
  modport sink   (input valid, input speed_mm_s, input sample_taken, input rejected,
                  output ready);
endinterface

// ----- sv/wheel_speed_estimator_core.sv -----
// Wheel speed estimator core: period divider, sample ring and moving average, one wheel.
//
// Usage: one instance per wheel. The item channel carries an opcode and a microsecond
// timestamp; opcode edge marks a sensor edge, opcode check asks for the stall test.
// Every item gives exactly one result-channel transaction with the filtered speed and
// the sample_taken / rejected flags. The user writes the registers (distance per edge,
// stall timeout, spike margin) over the APB port while the block is idle; not enforced.
//
// Flow: an edge after the first one is loaded and runs a bit-serial restoring divider,
// one quotient bit per cycle, for distance*1000/interval over the 26 dividend bits;
// then the ring is updated, the ring mean is divided out over the 16+clog2(WINDOW_DEPTH)
// bits of the sum (20 at depth 10), and the spike test and output steps run.
// The first edge and a check item go straight from load to output. One item is in
// work at a time; the next item is taken once the result sits in the output register,
// so a result held by a stalled receiver overlaps the next item.
//
// Reset (rst, synchronous) restores register defaults, clears the ring valid bits, the
// running sum, the speed and the edge history, and drops any pending result. When the
// receiver stalls the result stays in the output register and further results wait.
module wheel_speed_estimator_core #(
  parameter int WINDOW_DEPTH = wse_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  wse_item_if.sink                    item,
  wse_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wse_pkg::ADDR_W-1:0]  paddr,
  input  logic [wse_pkg::DATA_W-1:0]  pwdata,
  output logic [wse_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int POS_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = wse_pkg::SPEED_W + $clog2(WINDOW_DEPTH);
  localparam int TW    = wse_pkg::TIME_W;

  // Configuration registers
  logic [wse_pkg::DIST_W-1:0]   distance_per_tick_um;
  logic [wse_pkg::TMO_W-1:0]    stall_timeout_us;
  logic [wse_pkg::MARGIN_W-1:0] spike_margin_mm_s;

  // Estimator state
  wse_pkg::state_t              state, state_next;
  logic [TW-1:0]                last_edge_time;
  logic                         edge_seen;
  logic [POS_W-1:0]             ring_write_pos;
  logic [WINDOW_DEPTH-1:0]      ring_valid;
  logic [wse_pkg::SPEED_W-1:0]  ring_mem [WINDOW_DEPTH];
  logic [wse_pkg::SPEED_W-1:0]  ring_rdata;
  logic [SUM_W-1:0]             ring_sum;
  logic [wse_pkg::SPEED_W-1:0]  speed_now;

  // Divider registers
  logic [wse_pkg::PROD_W-1:0]   dvd;
  logic [wse_pkg::PROD_W-1:0]   quo;
  logic [TW-1:0]                rem;
  logic [TW-1:0]                divisor;
  logic [wse_pkg::CNT_W-1:0]    cnt;

  // Pending result fields and output register
  logic                         res_taken;
  logic                         res_rej;
  logic                         out_valid;
  logic [wse_pkg::SPEED_W-1:0]  out_speed;
  logic                         out_taken;
  logic                         out_rej;

  // Control
  logic                         accept;
  logic                         load_out;
  logic                         cfg_wr;

  // Datapath combinational values
  logic [TW:0]                  rem_sh;
  logic                         div_ge;
  logic [TW:0]                  rem_sub;
  logic [TW-1:0]                elapsed;
  logic [wse_pkg::SPEED_W-1:0]  sample;
  logic [wse_pkg::SPEED_W-1:0]  old_entry;
  logic [SUM_W-1:0]             sum_next;
  logic [wse_pkg::SPEED_W:0]    spike_limit;

  // APB configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_tick_um <= wse_pkg::DIST_RST;
      stall_timeout_us     <= wse_pkg::TIMEOUT_RST;
      spike_margin_mm_s    <= wse_pkg::MARGIN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wse_pkg::REG_DIST:    distance_per_tick_um <= pwdata[wse_pkg::DIST_W-1:0];
        wse_pkg::REG_TIMEOUT: stall_timeout_us     <= pwdata[wse_pkg::TMO_W-1:0];
        wse_pkg::REG_MARGIN:  spike_margin_mm_s    <= pwdata[wse_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wse_pkg::REG_DIST:    prdata = wse_pkg::DATA_W'(distance_per_tick_um);
      wse_pkg::REG_TIMEOUT: prdata = wse_pkg::DATA_W'(stall_timeout_us);
      wse_pkg::REG_MARGIN:  prdata = wse_pkg::DATA_W'(spike_margin_mm_s);
      default:              prdata = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wse_pkg::S_IDLE: begin
        if (accept) begin
          if (item.opcode == wse_pkg::OP_EDGE && edge_seen) state_next = wse_pkg::S_PERIOD;
          else state_next = wse_pkg::S_DONE;
        end
      end
      wse_pkg::S_PERIOD: if (cnt == wse_pkg::CNT_W'(1)) state_next = wse_pkg::S_SUM;
      wse_pkg::S_SUM:    state_next = wse_pkg::S_MEAN;
      wse_pkg::S_MEAN:   if (cnt == wse_pkg::CNT_W'(1)) state_next = wse_pkg::S_TEST;
      wse_pkg::S_TEST:   state_next = wse_pkg::S_DONE;
      wse_pkg::S_DONE:   if (load_out) state_next = wse_pkg::S_IDLE;
      default:           state_next = wse_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    item.ready = (state == wse_pkg::S_IDLE);
    accept     = item.valid & (state == wse_pkg::S_IDLE);
    load_out   = (state == wse_pkg::S_DONE) & (~out_valid | result.ready);
  end

  assign result.valid        = out_valid;
  assign result.speed_mm_s   = out_speed;
  assign result.sample_taken = out_taken;
  assign result.rejected     = out_rej;

  // One restoring division step
  assign rem_sh  = {rem, dvd[wse_pkg::PROD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Saturate the period quotient and update the running ring sum
  assign elapsed     = item.time_us - last_edge_time;
  assign sample      = (|quo[wse_pkg::PROD_W-1:wse_pkg::SPEED_W]) ? '1
                       : quo[wse_pkg::SPEED_W-1:0];
  assign old_entry   = ring_valid[ring_write_pos] ? ring_rdata : '0;
  assign sum_next    = (ring_sum - SUM_W'(old_entry)) + SUM_W'(sample);
  assign spike_limit = {1'b0, speed_now} + {1'b0, spike_margin_mm_s};

  // Ring memory: write in the update cycle, registered read at the write position
  always_ff @(posedge clk) begin
    if (state == wse_pkg::S_SUM) ring_mem[ring_write_pos] <= sample;
    ring_rdata <= ring_mem[ring_write_pos];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= wse_pkg::S_IDLE;
      last_edge_time <= '0;
      edge_seen      <= 1'b0;
      ring_write_pos <= '0;
      ring_valid     <= '0;
      ring_sum       <= '0;
      speed_now      <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      if (accept) begin
        if (item.opcode == wse_pkg::OP_EDGE) begin
          edge_seen      <= 1'b1;
          last_edge_time <= item.time_us;
        end else if (elapsed > TW'(stall_timeout_us)) begin
          speed_now <= '0;
        end
      end

      if (state == wse_pkg::S_SUM) begin
        ring_valid[ring_write_pos] <= 1'b1;
        ring_sum <= sum_next;
        if (ring_write_pos == POS_W'(WINDOW_DEPTH - 1)) ring_write_pos <= '0;
        else ring_write_pos <= ring_write_pos + POS_W'(1);
      end

      if (state == wse_pkg::S_TEST && {1'b0, quo[wse_pkg::SPEED_W-1:0]} < spike_limit)
        speed_now <= quo[wse_pkg::SPEED_W-1:0];
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    case (state)
      wse_pkg::S_IDLE: begin
        res_taken <= 1'b0;
        res_rej   <= 1'b0;
        divisor   <= elapsed;
        dvd       <= wse_pkg::PROD_W'({10'd0, distance_per_tick_um} * wse_pkg::UM_PER_MM);
        rem       <= '0;
        quo       <= '0;
        cnt       <= wse_pkg::CNT_W'(wse_pkg::PROD_W);
      end
      wse_pkg::S_PERIOD, wse_pkg::S_MEAN: begin
        rem <= div_ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
        quo <= {quo[wse_pkg::PROD_W-2:0], div_ge};
        dvd <= {dvd[wse_pkg::PROD_W-2:0], 1'b0};
        cnt <= cnt - wse_pkg::CNT_W'(1);
      end
      wse_pkg::S_SUM: begin
        // Left-align the sum so only its own bits are iterated
        divisor <= TW'(WINDOW_DEPTH);
        dvd     <= wse_pkg::PROD_W'(sum_next) << (wse_pkg::PROD_W - SUM_W);
        rem     <= '0;
        quo     <= '0;
        cnt     <= wse_pkg::CNT_W'(SUM_W);
      end
      wse_pkg::S_TEST: begin
        res_taken <= 1'b1;
        res_rej   <= ~({1'b0, quo[wse_pkg::SPEED_W-1:0]} < spike_limit);
      end
      default: ;
    endcase

    if (load_out) begin
      out_speed <= speed_now;
      out_taken <= res_taken;
      out_rej   <= res_rej;
    end
  end

endmodule

// ----- sv/wse_checker.sv -----
// Port-level checker for the wheel speed estimator core, with its bind.
module wse_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [wse_pkg::SPEED_W-1:0] speed_mm_s,
  input logic                        sample_taken,
  input logic                        rejected
);

  // No result survives reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(speed_mm_s)
      && $stable(sample_taken) && $stable(rejected))
    else $error("stalled result changed");

  // One item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while busy");

  // Only a new sample can be rejected
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !rejected || sample_taken)
    else $error("rejected without a sample");

endmodule

bind wheel_speed_estimator_core wse_checker u_wse_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .speed_mm_s   (result.speed_mm_s),
  .sample_taken (result.sample_taken),
  .rejected     (result.rejected)
);
